// ===== sv/dof_pkg.sv =====
// dof_pkg: shared types, register indexes and defaults for the delimiter occurrence finder
// no dependencies; imported by every module of the block
package dof_pkg;

	localparam int DEF_MAX_DELIMITER_BYTES = 8;
	localparam int DEF_MAX_FRAME_BYTES     = 65535;

	localparam int DELIM_W = 64;
	localparam int LEN_W   = 4;
	localparam int OCC_W   = 8;
	localparam int MODE_W  = 2;
	localparam int POS_W   = 16;
	localparam int OUT_W   = 24;

	localparam logic [1:0] REG_DELIM_BYTES = 2'd0;
	localparam logic [1:0] REG_DELIM_LEN   = 2'd1;
	localparam logic [1:0] REG_OCC_NUM     = 2'd2;
	localparam logic [1:0] REG_MODE        = 2'd3;

	localparam logic [MODE_W-1:0] MODE_NTH_START = 2'd0;
	localparam logic [MODE_W-1:0] MODE_FIRST_END = 2'd1;
	localparam logic [MODE_W-1:0] MODE_LAST_END  = 2'd2;

	typedef struct packed {
		logic [DELIM_W-1:0] delim_bytes;
		logic [LEN_W-1:0]   delim_nbytes;
		logic [OCC_W-1:0]   occ_num;
		logic [MODE_W-1:0]  mode;
	} cfg_t;

	typedef struct packed {
		logic             overflow;
		logic [POS_W-1:0] position;
		logic             found;
	} result_t;

endpackage

// ===== sv/dof_search_core.sv =====
// dof_search_core: frame state, sliding window compare and occurrence bookkeeping
// depends on dof_pkg; steps once per byte handed over by the top level
module dof_search_core import dof_pkg::*; #(
	parameter int MAX_DELIMITER_BYTES = DEF_MAX_DELIMITER_BYTES,
	parameter int MAX_FRAME_BYTES     = DEF_MAX_FRAME_BYTES
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] data_byte,
	input  logic       frame_end,
	input  cfg_t       cfg,
	output result_t    res
);

	localparam int WIN_W  = 8 * MAX_DELIMITER_BYTES;
	localparam int FILL_W = $clog2(MAX_DELIMITER_BYTES + 1);
	localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(MAX_DELIMITER_BYTES);
	localparam logic [LEN_W-1:0]  LEN_MAX  = LEN_W'(MAX_DELIMITER_BYTES);
	localparam logic [POS_W-1:0]  FRAME_MAX = POS_W'(MAX_FRAME_BYTES);

	logic [WIN_W-1:0]  window_q, window_d;
	logic [FILL_W-1:0] fill_q, fill_d;
	logic [POS_W-1:0]  byte_idx_q, byte_idx_d;
	logic [OCC_W-1:0]  matches_q, matches_d;
	logic [POS_W-1:0]  held_pos_q, held_pos_d;
	logic              held_found_q, held_found_d;
	logic              sat_q, sat_d;

	logic [LEN_W-1:0]  len;
	logic [POS_W-1:0]  idx_p1;
	logic [MAX_DELIMITER_BYTES-1:0] byte_hit;
	logic              match;

	always_comb begin
		if (cfg.delim_nbytes == '0) begin
			len = LEN_W'(1);
		end else if (cfg.delim_nbytes > LEN_MAX) begin
			len = LEN_MAX;
		end else begin
			len = cfg.delim_nbytes;
		end
	end

	assign window_d = WIN_W'({window_q, data_byte});
	assign fill_d   = (fill_q == FILL_MAX) ? fill_q : fill_q + FILL_W'(1);
	assign idx_p1   = byte_idx_q + POS_W'(1);

	always_comb begin
		for (int k = 0; k < MAX_DELIMITER_BYTES; k++) begin
			byte_hit[k] = (LEN_W'(k) >= len) ||
				(window_d[8*k +: 8] == cfg.delim_bytes[8*k +: 8]);
		end
	end

	assign match = (&byte_hit) && (LEN_W'(fill_d) >= len);

	always_comb begin
		matches_d    = matches_q;
		held_pos_d   = held_pos_q;
		held_found_d = held_found_q;
		sat_d        = sat_q;
		byte_idx_d   = byte_idx_q;
		if (byte_idx_q >= FRAME_MAX) begin
			sat_d = 1'b1;
		end else begin
			byte_idx_d = idx_p1;
			if (match) begin
				unique case (cfg.mode)
					MODE_NTH_START: begin
						if (!held_found_q) begin
							matches_d = (matches_q == '1) ? matches_q : matches_q + OCC_W'(1);
							if (cfg.occ_num != '0 && matches_d == cfg.occ_num) begin
								held_found_d = 1'b1;
								held_pos_d   = idx_p1 - POS_W'(len);
							end
						end
					end
					MODE_FIRST_END: begin
						if (!held_found_q) begin
							held_found_d = 1'b1;
							held_pos_d   = idx_p1;
						end
					end
					MODE_LAST_END: begin
						held_found_d = 1'b1;
						held_pos_d   = idx_p1;
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_comb begin
		res.found    = held_found_d;
		res.position = held_found_d ? held_pos_d : '0;
		res.overflow = sat_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q     <= '0;
			fill_q       <= '0;
			byte_idx_q   <= '0;
			matches_q    <= '0;
			held_pos_q   <= '0;
			held_found_q <= 1'b0;
			sat_q        <= 1'b0;
		end else if (step) begin
			if (frame_end) begin
				window_q     <= '0;
				fill_q       <= '0;
				byte_idx_q   <= '0;
				matches_q    <= '0;
				held_pos_q   <= '0;
				held_found_q <= 1'b0;
				sat_q        <= 1'b0;
			end else begin
				window_q     <= byte_idx_q >= FRAME_MAX ? window_q : window_d;
				fill_q       <= byte_idx_q >= FRAME_MAX ? fill_q : fill_d;
				byte_idx_q   <= byte_idx_d;
				matches_q    <= matches_d;
				held_pos_q   <= held_pos_d;
				held_found_q <= held_found_d;
				sat_q        <= sat_d;
			end
		end
	end

endmodule

// ===== sv/dof_out_stage.sv =====
// dof_out_stage: result register driving the master-side stream
// depends on dof_pkg; loaded by the top level at each frame end
module dof_out_stage import dof_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  result_t          res,
	output logic             free,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata
);

	logic    valid_q;
	result_t res_q;

	assign free     = !valid_q || m_tready;
	assign m_tvalid = valid_q;
	assign m_tdata  = OUT_W'(res_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

endmodule

// ===== sv/delimiter_occurrence_finder_unit.sv =====
// delimiter_occurrence_finder_unit: top level with input register, config registers and stages
// depends on dof_pkg, dof_search_core and dof_out_stage
//
// Searches a frame of bytes, one byte per item on the slave stream with tlast on the final byte,
// for overlapping occurrences of a 1 to MAX_DELIMITER_BYTES byte delimiter. One result item
// leaves per frame: found flag, position (nth start index, first end offset or last end offset
// per search_mode) and an overflow flag for frames beyond MAX_FRAME_BYTES. Each byte is held in
// the input register and matched from there; a new byte is taken every cycle unless input stalls,
// and a frame's result goes from the input register through the result register to the master
// stream. Only a held result that is not taken stalls input, and only at the next frame end.
// Configuration writes are always ready and act on bytes matched after the write.
module delimiter_occurrence_finder_unit import dof_pkg::*; #(
	parameter int MAX_DELIMITER_BYTES = DEF_MAX_DELIMITER_BYTES,
	parameter int MAX_FRAME_BYTES     = DEF_MAX_FRAME_BYTES
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [7:0]         s_tdata,   // data_byte
	input  logic               s_tlast,   // frame_end
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [OUT_W-1:0]   m_tdata,   // found, position[15:0], overflow, zero fill
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [DELIM_W-1:0] cfg_data
);

	cfg_t       cfg_q;
	logic       in_valid_s1;
	logic [7:0] in_byte_s1;
	logic       in_last_s1;
	logic       step;
	logic       out_free;
	result_t    res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.delim_bytes  <= '0;
			cfg_q.delim_nbytes <= LEN_W'(1);
			cfg_q.occ_num      <= OCC_W'(1);
			cfg_q.mode         <= MODE_NTH_START;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_DELIM_BYTES: cfg_q.delim_bytes  <= cfg_data;
				REG_DELIM_LEN:   cfg_q.delim_nbytes <= cfg_data[LEN_W-1:0];
				REG_OCC_NUM:     cfg_q.occ_num      <= cfg_data[OCC_W-1:0];
				REG_MODE:        cfg_q.mode         <= cfg_data[MODE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign step     = in_valid_s1 && (!in_last_s1 || out_free);
	assign s_tready = !in_valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_tready) begin
			in_valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			in_byte_s1 <= s_tdata;
			in_last_s1 <= s_tlast;
		end
	end

	dof_search_core #(
		.MAX_DELIMITER_BYTES(MAX_DELIMITER_BYTES),
		.MAX_FRAME_BYTES    (MAX_FRAME_BYTES)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.data_byte(in_byte_s1),
		.frame_end(in_last_s1),
		.cfg      (cfg_q),
		.res      (res)
	);

	dof_out_stage u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (step && in_last_s1),
		.res     (res),
		.free    (out_free),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

endmodule

// ===== sim/tb.sv =====
// tb: self-checking bench for delimiter_occurrence_finder_unit, byte frames in, one result per frame
// depends on dof_pkg and the unit; frames, register settings and idling are directed then random
`timescale 1ns / 100ps

module tb;
	import dof_pkg::*;

	localparam int LIMIT = 2_000_000;
	localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;

	typedef struct {
		logic [7:0] data;
		logic       is_end;
	} frame_byte_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [7:0]        s_tdata = '0;
	logic              s_tlast = 1'b0;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [OUT_W-1:0]  m_tdata;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [1:0]        cfg_index = '0;
	logic [DELIM_W-1:0] cfg_data = '0;

	frame_byte_t pend_items[$];
	result_t     expected_results[$];
	int          errors = 0;
	int          cycles = 0;
	int          src_idle_pct = 0;
	int          snk_stall_pct = 0;

	// predictor copy of registers and frame state
	logic [63:0] cfg_delim = '0;
	logic [3:0]  cfg_len = 4'd1;
	logic [7:0]  cfg_occ = 8'd1;
	logic [1:0]  cfg_mode = MODE_NTH_START;
	logic [63:0] win = '0;
	int          fill = 0;
	int unsigned byte_count = 0;
	int          match_cnt = 0;
	logic [15:0] held_pos = '0;
	logic        held_found = 1'b0;
	logic        saturated = 1'b0;

	delimiter_occurrence_finder_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic int eff_len();
		int len;
		len = cfg_len;
		if (len == 0)
			len = 1;
		if (len > DEF_MAX_DELIMITER_BYTES)
			len = DEF_MAX_DELIMITER_BYTES;
		return len;
	endfunction

	function automatic void search_byte(logic [7:0] b, logic is_end);
		int          len;
		int unsigned idx;
		logic [63:0] mask;
		result_t     r;
		len = eff_len();
		if (byte_count >= DEF_MAX_FRAME_BYTES) begin
			saturated = 1'b1;
		end else begin
			mask = (len >= 8) ? '1 : ((64'd1 << (8 * len)) - 64'd1);
			idx = byte_count;
			win = {win[55:0], b};
			if (fill < 8)
				fill++;
			byte_count = idx + 1;
			if (fill >= len && (win & mask) == (cfg_delim & mask)) begin
				case (cfg_mode)
					MODE_NTH_START: begin
						if (!held_found) begin
							if (match_cnt < 255)
								match_cnt++;
							if (cfg_occ != 0 && match_cnt == int'(cfg_occ)) begin
								held_found = 1'b1;
								held_pos = 16'(idx + 1 - len);
							end
						end
					end
					MODE_FIRST_END: begin
						if (!held_found) begin
							held_found = 1'b1;
							held_pos = 16'(idx + 1);
						end
					end
					MODE_LAST_END: begin
						held_found = 1'b1;
						held_pos = 16'(idx + 1);
					end
					default: ;
				endcase
			end
		end
		if (is_end) begin
			r.found = held_found;
			r.position = held_found ? held_pos : 16'd0;
			r.overflow = saturated;
			expected_results.push_back(r);
			win = '0;
			fill = 0;
			byte_count = 0;
			match_cnt = 0;
			held_pos = '0;
			held_found = 1'b0;
			saturated = 1'b0;
		end
	endfunction

	// byte stream driver
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || s_tready) begin
			if (pend_items.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
				s_tvalid <= 1'b1;
				s_tdata <= pend_items[0].data;
				s_tlast <= pend_items[0].is_end;
				void'(pend_items.pop_front());
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n)
			m_tready <= 1'b0;
		else
			m_tready <= ($urandom_range(99) >= snk_stall_pct);
	end

	// accepted items go to the predictor, results are checked against it
	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				search_byte(s_tdata, s_tlast);
			if (m_tvalid && m_tready) begin
				got = result_t'(m_tdata[$bits(result_t)-1:0]);
				if (expected_results.size() == 0) begin
					$error("unexpected result item: found %0d position %0d overflow %0d",
						got.found, got.position, got.overflow);
					errors++;
				end else begin
					want = expected_results.pop_front();
					if (got.found !== want.found) begin
						$error("found: expected %0d, got %0d", want.found, got.found);
						errors++;
					end
					if (got.position !== want.position) begin
						$error("position: expected %0d, got %0d", want.position, got.position);
						errors++;
					end
					if (got.overflow !== want.overflow) begin
						$error("overflow: expected %0d, got %0d", want.overflow, got.overflow);
						errors++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic cfg_write(logic [1:0] idx, logic [63:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_DELIM_BYTES: cfg_delim = value;
			REG_DELIM_LEN:   cfg_len = value[3:0];
			REG_OCC_NUM:     cfg_occ = value[7:0];
			REG_MODE:        cfg_mode = value[1:0];
			default: ;
		endcase
	endtask

	task automatic wait_idle();
		do @(posedge clk);
		while (pend_items.size() != 0 || s_tvalid || expected_results.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_idling(int sel);
		case (sel % 4)
			0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
			1: begin src_idle_pct = 54; snk_stall_pct = 0;  end
			2: begin src_idle_pct = 0;  snk_stall_pct = 54; end
			default: begin src_idle_pct = 17; snk_stall_pct = 17; end
		endcase
	endtask

	task automatic push_item(logic [7:0] b, logic is_end);
		frame_byte_t it;
		it.data = b;
		it.is_end = is_end;
		pend_items.push_back(it);
	endtask

	// frame of n bytes taken from w, first byte in the most significant used position
	task automatic add_word_frame(logic [63:0] w, int n);
		int k;
		for (k = 0; k < n; k++)
			push_item(w[8 * (n - 1 - k) +: 8], k == n - 1);
	endtask

	task automatic add_random_frame(int n);
		logic [7:0] fr[$];
		int         dl;
		int         k;
		int         j;
		int         pos;
		int         plants;
		logic       narrow;
		dl = eff_len();
		narrow = $urandom_range(1);
		for (k = 0; k < n; k++) begin
			if (narrow && $urandom_range(9) < 8)
				fr.push_back(cfg_delim[8 * $urandom_range(dl - 1) +: 8]);
			else
				fr.push_back(8'($urandom));
		end
		plants = (n >= dl) ? $urandom_range(3) : 0;
		for (j = 0; j < plants; j++) begin
			pos = $urandom_range(n - dl);
			for (k = 0; k < dl; k++)
				fr[pos + k] = cfg_delim[8 * (dl - 1 - k) +: 8];
		end
		for (k = 0; k < n; k++)
			push_item(fr[k], k == n - 1);
	endtask

	task automatic random_config();
		logic [63:0] v;
		int          roll;
		cfg_write(REG_DELIM_BYTES, {$urandom, $urandom});
		v = {$urandom, $urandom};
		roll = $urandom_range(99);
		if (roll < 70)
			v[3:0] = 4'($urandom_range(1, 4));
		else if (roll < 85)
			v[3:0] = 4'($urandom_range(5, 8));
		else if (roll < 92)
			v[3:0] = 4'd0;
		else
			v[3:0] = 4'($urandom_range(9, 15));
		cfg_write(REG_DELIM_LEN, v);
		v = {$urandom, $urandom};
		roll = $urandom_range(99);
		if (roll < 60)
			v[7:0] = 8'($urandom_range(1, 3));
		else if (roll < 80)
			v[7:0] = 8'($urandom_range(4, 10));
		else if (roll < 90)
			v[7:0] = 8'd0;
		else
			v[7:0] = 8'($urandom);
		cfg_write(REG_OCC_NUM, v);
		v = {$urandom, $urandom};
		roll = $urandom_range(99);
		if (roll < 30)
			v[1:0] = MODE_NTH_START;
		else if (roll < 60)
			v[1:0] = MODE_FIRST_END;
		else if (roll < 90)
			v[1:0] = MODE_LAST_END;
		else
			v[1:0] = MODE_NONE;
		cfg_write(REG_MODE, v);
	endtask

	initial begin
		int phase;
		int nframes;
		int f;
		int k;
		int rand_items;
		int len;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// reset defaults: delimiter 0x00, length 1, first occurrence start
		set_idling(1);
		add_word_frame(64'h00FF00, 3);
		add_word_frame(64'hFF, 1);
		wait_idle();

		// two byte delimiter with overlaps, bits above the length ignored
		set_idling(2);
		cfg_write(REG_DELIM_BYTES, 64'h1234_5678_9ABC_ABAB);
		cfg_write(REG_DELIM_LEN, 64'd2);
		cfg_write(REG_OCC_NUM, 64'd2);
		cfg_write(REG_MODE, 64'(MODE_NTH_START));
		add_word_frame(64'hABABABAB, 4);
		wait_idle();
		cfg_write(REG_MODE, 64'(MODE_FIRST_END));
		add_word_frame(64'hABABABAB, 4);
		wait_idle();
		cfg_write(REG_MODE, 64'(MODE_LAST_END));
		add_word_frame(64'hABABABAB, 4);
		wait_idle();

		// length zero acts as one
		set_idling(3);
		cfg_write(REG_DELIM_BYTES, '1);
		cfg_write(REG_DELIM_LEN, 64'd0);
		add_word_frame(64'hFF00FF00, 4);
		wait_idle();

		// length above eight acts as eight, and a frame shorter than the delimiter
		cfg_write(REG_DELIM_LEN, 64'd15);
		cfg_write(REG_MODE, 64'(MODE_FIRST_END));
		add_word_frame('1, 8);
		add_word_frame('1, 7);
		wait_idle();

		// occurrence zero never matches, mode three never matches
		set_idling(0);
		cfg_write(REG_DELIM_BYTES, 64'd0);
		cfg_write(REG_DELIM_LEN, 64'd1);
		cfg_write(REG_OCC_NUM, 64'd0);
		cfg_write(REG_MODE, 64'(MODE_NTH_START));
		add_word_frame(64'h0000, 2);
		wait_idle();
		cfg_write(REG_MODE, 64'(MODE_NONE));
		add_word_frame(64'h00, 1);
		wait_idle();

		// highest occurrence number in a long run of matches
		cfg_write(REG_OCC_NUM, 64'd255);
		cfg_write(REG_MODE, 64'(MODE_NTH_START));
		for (k = 0; k < 300; k++)
			push_item(8'h00, k == 299);
		wait_idle();

		// random settings, each with a run of frames
		rand_items = 0;
		phase = 0;
		while (rand_items < 1400) begin
			set_idling(phase);
			random_config();
			nframes = $urandom_range(5, 15);
			for (f = 0; f < nframes; f++) begin
				if ($urandom_range(9) == 0)
					len = $urandom_range(40, 120);
				else
					len = $urandom_range(1, 24);
				add_random_frame(len);
				rand_items += len;
			end
			wait_idle();
			phase++;
		end

		repeat (16) @(posedge clk);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
